@@ sv/debug_packet_deframer_assert.svh @@
// Assertion macros used by the packet deframer core.
`ifndef DEBUG_PACKET_DEFRAMER_ASSERT_SVH
`define DEBUG_PACKET_DEFRAMER_ASSERT_SVH

// Same-cycle implication checked on every clock edge outside reset.
`define DPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked on every clock edge outside reset.
`define DPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/dpd_pkg.sv @@
// Types, character codes and the hex digit decoder of the packet deframer.
`default_nettype none

package dpd_pkg;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_HASH   = 8'h23;
  localparam logic [7:0] CHAR_0      = 8'h30;
  localparam logic [7:0] CHAR_9      = 8'h39;
  localparam logic [7:0] CHAR_UA     = 8'h41;
  localparam logic [7:0] CHAR_UF     = 8'h46;
  localparam logic [7:0] CHAR_LA     = 8'h61;
  localparam logic [7:0] CHAR_LF     = 8'h66;
  localparam logic [7:0] HEX_INVALID = 8'hFF;
  localparam logic [7:0] HEX_TEN     = 8'd10;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_GOOD  = 2'd1,
    KIND_BAD   = 2'd2,
    KIND_ABORT = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       closed;
  } item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;
    logic       send_ack;
  } result_t;

  // Returns 0 to 15 for a hex digit of either case, and all ones otherwise.
  function automatic logic [7:0] hex_value(input logic [7:0] b);
    logic [7:0] v;
    if (b >= CHAR_0 && b <= CHAR_9) begin
      v = b - CHAR_0;
    end else if (b >= CHAR_UA && b <= CHAR_UF) begin
      v = b - CHAR_UA + HEX_TEN;
    end else if (b >= CHAR_LA && b <= CHAR_LF) begin
      v = b - CHAR_LA + HEX_TEN;
    end else begin
      v = HEX_INVALID;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

@@ sv/debug_packet_deframer.sv @@
// Top level of the debug link packet deframer.
// A word accepted is held in the input register, and its result is then loaded into the result register.
// Throughput: one word per cycle while the result register has room; the input and result registers sustain that rate.
// Words that cause no result still pass through the input register.
// Reset is asynchronous and active low and returns the deframer to hunting for a start.
// Reset clears the payload sum, the high digit and both valid flags.
`default_nettype none

module debug_packet_deframer
  import dpd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       closed_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      result_kind_o,
  output logic [7:0]      data_o,
  output logic [7:0]      computed_sum_o,
  output logic [7:0]      received_sum_o,
  output logic            send_ack_o
);

  item_t   in_item;
  item_t   held_item;
  logic    item_valid;
  logic    consume;
  logic    out_free;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign in_item.rx_byte = rx_byte_i;
  assign in_item.closed  = closed_i;

  dpd_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .item_i       (in_item),
    .consume_i    (consume),
    .item_valid_o (item_valid),
    .item_o       (held_item)
  );

  dpd_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (held_item),
    .out_free_i   (out_free),
    .consume_o    (consume),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  dpd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign result_kind_o  = out_res.kind;
  assign data_o         = out_res.data;
  assign computed_sum_o = out_res.computed_sum;
  assign received_sum_o = out_res.received_sum;
  assign send_ack_o     = out_res.send_ack;

endmodule

`default_nettype wire

@@ sv/dpd_in_stage.sv @@
// Input register that holds one received word until the core takes it.
`default_nettype none

module dpd_in_stage
  import dpd_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire item_t item_i,
  input  wire logic  consume_i,
  output logic       item_valid_o,
  output item_t      item_o
);

  logic  valid_q;
  item_t item_q;

  assign in_ready_o   = !valid_q || consume_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (consume_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

`default_nettype wire

@@ sv/dpd_core.sv @@
// Framing state, payload sum and checksum compare for one word per cycle while the result register has room.
`default_nettype none

`include "debug_packet_deframer_assert.svh"

module dpd_core
  import dpd_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  item_valid_i,
  input  wire item_t item_i,
  input  wire logic  out_free_i,
  output logic       consume_o,
  output logic       res_valid_o,
  output result_t    res_o
);

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_DATA = 2'd1,
    PH_HIGH = 2'd2,
    PH_LOW  = 2'd3
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] high_q, high_d;
  logic       has_res;
  logic [7:0] digit;
  logic [7:0] rsum;

  assign consume_o   = item_valid_i && out_free_i;
  assign res_valid_o = consume_o && has_res;
  assign digit       = hex_value(item_i.rx_byte);
  assign rsum        = high_q | digit;

  always_comb begin
    phase_d = phase_q;
    sum_d   = sum_q;
    high_d  = high_q;
    has_res = 1'b0;
    res_o   = '0;
    if (item_i.closed) begin
      phase_d    = PH_HUNT;
      has_res    = 1'b1;
      res_o.kind = KIND_ABORT;
    end else begin
      unique case (phase_q)
        PH_HUNT: begin
          if (item_i.rx_byte == CHAR_DOLLAR) begin
            sum_d   = '0;
            phase_d = PH_DATA;
          end
        end
        PH_DATA: begin
          if (item_i.rx_byte == CHAR_HASH) begin
            phase_d = PH_HIGH;
          end else begin
            sum_d      = sum_q + item_i.rx_byte;
            has_res    = 1'b1;
            res_o.kind = KIND_BYTE;
            res_o.data = item_i.rx_byte;
          end
        end
        PH_HIGH: begin
          high_d  = {digit[3:0], 4'h0};
          phase_d = PH_LOW;
        end
        PH_LOW: begin
          phase_d            = PH_HUNT;
          has_res            = 1'b1;
          res_o.computed_sum = sum_q;
          res_o.received_sum = rsum;
          res_o.send_ack     = (rsum == sum_q);
          res_o.kind         = (rsum == sum_q) ? KIND_GOOD : KIND_BAD;
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      sum_q   <= '0;
      high_q  <= '0;
    end else if (consume_o) begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
      high_q  <= high_d;
    end
  end

  `DPD_ASSERT_NOW(a_data_only_for_bytes,
    res_valid_o && res_o.kind != KIND_BYTE, res_o.data == 8'h00,
    "Data is nonzero on a result that is not a payload byte.")
  `DPD_ASSERT_NOW(a_ack_means_match,
    res_valid_o && res_o.send_ack, res_o.received_sum == res_o.computed_sum,
    "Acknowledge requested for a packet whose checksum does not match.")
  `DPD_ASSERT_NEXT(a_close_returns_to_hunt,
    consume_o && item_i.closed, phase_q == PH_HUNT,
    "A closed link did not return the deframer to hunting.")
  `DPD_ASSERT_NEXT(a_low_digit_ends_packet,
    consume_o && phase_q == PH_LOW, phase_q == PH_HUNT,
    "The low checksum digit did not end the packet.")

endmodule

`default_nettype wire

@@ sv/dpd_out_stage.sv @@
// Result register that holds one result word until the consumer takes it.
`default_nettype none

module dpd_out_stage
  import dpd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire result_t res_i,
  output logic         out_free_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output result_t      res_o
);

  logic    valid_q;
  result_t res_q;

  assign out_free_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire
